FILE: rtl/cfd_pkg.sv
`timescale 1ns / 1ps

package cfd_pkg;

  // Header layout (byte offsets within a frame)
  localparam int unsigned TYPE_POS     = 7;
  localparam int unsigned ID_FIRST     = 8;
  localparam int unsigned ID_LAST      = 15;
  localparam int unsigned LEN_HI_POS   = 16;
  localparam int unsigned LEN_LO_POS   = 17;
  localparam int unsigned CSUM_HI_POS  = 18;
  localparam int unsigned CSUM_LO_POS  = 19;
  localparam int unsigned INDEX_POS    = 20;
  localparam int unsigned COUNT_POS    = 21;
  localparam int unsigned FNUM_HI_POS  = 22;
  localparam int unsigned FNUM_LO_POS  = 23;
  localparam int unsigned SUM_BYTES    = 18;
  localparam int unsigned HDR_BYTES    = 24;
  localparam int unsigned TYPE_OK_MIN  = 8;
  localparam int unsigned CSUM_OK_MIN  = 20;

  localparam logic [7:0]  TYPE_VALUE = 8'd1;
  localparam logic [15:0] LEN_BIAS   = 16'd4;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_TYPE = 2'd1,
    STATUS_BAD_CSUM = 2'd2,
    STATUS_BAD_LEN  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [7:0]  pkt_index;
    logic [7:0]  packet_count;
    logic [15:0] frame_number;
    logic [63:0] device_id;
    logic [15:0] payload_length;
    logic        end_of_run;
  } out_t;

  // Up to two results per request: first always fills before second
  typedef struct packed {
    logic first_valid;
    logic second_valid;
    out_t first;
    out_t second;
  } res_pair_t;

endpackage

FILE: rtl/cfd_frame_parser.sv
`timescale 1ns / 1ps

module cfd_frame_parser #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfd_pkg::in_t       in_data,
  input  logic               take,
  output cfd_pkg::res_pair_t res
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_FRAME_BYTES + 1);
  localparam logic [31:0] MAX_BYTES = 32'(MAX_FRAME_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [19:0]      sum_r, sum_nxt;
  logic [7:0]       even_r, even_nxt;
  logic             type_bad_r, type_bad_nxt;
  logic [15:0]      rx_csum_r, rx_csum_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic [7:0]       cnt_cap_r, cnt_cap_nxt;
  logic [15:0]      fnum_r, fnum_nxt;
  logic [63:0]      id_r, id_nxt;

  logic [POS_W-1:0] pos_inc;
  logic [31:0]      count;
  logic [31:0]      body_len;
  logic [16:0]      fold1;
  logic [15:0]      fold2;
  logic [15:0]      csum_calc;
  logic [15:0]      plen;
  logic [7:0]       b;
  logic             last;
  logic             is_body;
  cfd_pkg::status_t st;
  cfd_pkg::out_t    pay_res;
  cfd_pkg::out_t    st_res;

  always_comb begin
    b    = in_data.rx_byte;
    last = in_data.frame_end;

    even_nxt     = even_r;
    sum_nxt      = sum_r;
    type_bad_nxt = type_bad_r;
    id_nxt       = id_r;
    len_nxt      = len_r;
    rx_csum_nxt  = rx_csum_r;
    idx_nxt      = idx_r;
    cnt_cap_nxt  = cnt_cap_r;
    fnum_nxt     = fnum_r;

    // Accumulate little-endian words over the checksummed header
    if (pos_r < POS_W'(cfd_pkg::SUM_BYTES)) begin
      if (!pos_r[0]) begin
        even_nxt = b;
      end else begin
        sum_nxt = sum_r + {4'd0, b, even_r};
      end
    end

    if (pos_r == POS_W'(cfd_pkg::TYPE_POS)) begin
      type_bad_nxt = (b != cfd_pkg::TYPE_VALUE);
    end else if (pos_r >= POS_W'(cfd_pkg::ID_FIRST) && pos_r <= POS_W'(cfd_pkg::ID_LAST)) begin
      id_nxt = {id_r[55:0], b};
    end else if (pos_r == POS_W'(cfd_pkg::LEN_HI_POS) ||
                 pos_r == POS_W'(cfd_pkg::LEN_LO_POS)) begin
      len_nxt = {len_r[7:0], b};
    end else if (pos_r == POS_W'(cfd_pkg::CSUM_HI_POS) ||
                 pos_r == POS_W'(cfd_pkg::CSUM_LO_POS)) begin
      rx_csum_nxt = {rx_csum_r[7:0], b};
    end else if (pos_r == POS_W'(cfd_pkg::INDEX_POS)) begin
      idx_nxt = b;
    end else if (pos_r == POS_W'(cfd_pkg::COUNT_POS)) begin
      cnt_cap_nxt = b;
    end else if (pos_r == POS_W'(cfd_pkg::FNUM_HI_POS) ||
                 pos_r == POS_W'(cfd_pkg::FNUM_LO_POS)) begin
      fnum_nxt = {fnum_r[7:0], b};
    end

    // Saturate the byte counter one past the maximum frame size
    pos_inc = (pos_r < POS_SAT) ? pos_r + POS_W'(1) : pos_r;
    count   = 32'(pos_inc);

    // Sum is final whenever the checksum is checked, so fold the register
    fold1     = {1'b0, sum_r[15:0]} + {13'd0, sum_r[19:16]};
    fold2     = fold1[15:0] + {15'd0, fold1[16]};
    csum_calc = ~fold2;

    plen     = len_nxt - cfd_pkg::LEN_BIAS;
    body_len = count - 32'(cfd_pkg::HDR_BYTES);

    if (count >= 32'(cfd_pkg::TYPE_OK_MIN) && type_bad_nxt) begin
      st = cfd_pkg::STATUS_BAD_TYPE;
    end else if (count >= 32'(cfd_pkg::CSUM_OK_MIN) && rx_csum_nxt != csum_calc) begin
      st = cfd_pkg::STATUS_BAD_CSUM;
    end else if (count < 32'(cfd_pkg::HDR_BYTES) || count > MAX_BYTES) begin
      st = cfd_pkg::STATUS_BAD_LEN;
    end else if (plen != body_len[15:0]) begin
      st = cfd_pkg::STATUS_BAD_LEN;
    end else begin
      st = cfd_pkg::STATUS_OK;
    end

    is_body = (pos_r >= POS_W'(cfd_pkg::HDR_BYTES));

    pay_res              = '0;
    pay_res.kind         = cfd_pkg::KIND_PAYLOAD;
    pay_res.payload_byte = b;
    pay_res.status       = cfd_pkg::STATUS_OK;
    pay_res.end_of_run   = !last;

    st_res                = '0;
    st_res.kind           = cfd_pkg::KIND_STATUS;
    st_res.status         = st;
    st_res.pkt_index      = idx_nxt;
    st_res.packet_count   = cnt_cap_nxt;
    st_res.frame_number   = fnum_nxt;
    st_res.device_id      = id_nxt;
    st_res.payload_length = plen;
    st_res.end_of_run     = 1'b1;

    res.first_valid  = is_body || last;
    res.second_valid = is_body && last;
    res.first        = is_body ? pay_res : st_res;
    res.second       = st_res;

    pos_nxt = pos_inc;
    // Drop all frame state once the frame has ended
    if (last) begin
      pos_nxt      = '0;
      sum_nxt      = '0;
      even_nxt     = '0;
      type_bad_nxt = 1'b0;
      rx_csum_nxt  = '0;
      len_nxt      = '0;
      idx_nxt      = '0;
      cnt_cap_nxt  = '0;
      fnum_nxt     = '0;
      id_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      sum_r      <= '0;
      even_r     <= '0;
      type_bad_r <= 1'b0;
      rx_csum_r  <= '0;
      len_r      <= '0;
      idx_r      <= '0;
      cnt_cap_r  <= '0;
      fnum_r     <= '0;
      id_r       <= '0;
    end else if (take) begin
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      even_r     <= even_nxt;
      type_bad_r <= type_bad_nxt;
      rx_csum_r  <= rx_csum_nxt;
      len_r      <= len_nxt;
      idx_r      <= idx_nxt;
      cnt_cap_r  <= cnt_cap_nxt;
      fnum_r     <= fnum_nxt;
      id_r       <= id_nxt;
    end
  end

endmodule

FILE: rtl/checksummed_frame_deframer_unit.sv
`timescale 1ns / 1ps

// Frame deframer with header checksum check.
// Input channel (in_valid / in_stall / in_data): one frame byte per request,
// with frame_end marking the last byte of a frame.
// Output channel (out_valid / out_stall / out_data): one result per request.
// Bytes from offset 24 onward come out as payload results; the last byte of
// a frame also yields a status result carrying the captured header fields.
// Results are registered in the two-entry result queue before they are presented.
// Throughput: one byte per cycle while in_stall is low; a last byte that is
// itself payload yields two results, and the result queue drains them in turn.
// A byte is taken whenever the queue has room for every result it causes,
// so a new byte is accepted while an earlier result still waits on out_stall.
// When the receiver stalls, hold the queue contents; raise in_stall while the
// byte on offer needs more slots than remain after this cycle's drain.
// Reset (rst_n low, synchronous) clears frame state and empties the queue.
// Frames longer than MAX_FRAME_BYTES still forward payload but report a
// length error unless a type or checksum error takes priority.
module checksummed_frame_deframer_unit #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cfd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cfd_pkg::out_t out_data
);

  cfd_pkg::res_pair_t res;
  cfd_pkg::out_t      q_r [2];
  cfd_pkg::out_t      q_nxt [2];
  logic [1:0]         cnt_r, cnt_nxt;
  logic [1:0]         cnt_after_pop;
  logic [1:0]         need;
  logic [2:0]         fill;
  logic               pop;
  logic               take;

  // Header parse, checksum and status for the byte on the input port
  cfd_frame_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_data(in_data),
    .take   (take),
    .res    (res)
  );

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;

  // Room check: slots left after this cycle's drain must cover every result
  assign cnt_after_pop = cnt_r - {1'b0, pop};
  assign need          = {1'b0, res.first_valid} + {1'b0, res.second_valid};
  assign fill          = {1'b0, cnt_after_pop} + {1'b0, need};
  assign in_stall      = (fill > 3'd2);
  assign take          = in_valid && !in_stall;

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_after_pop;
    // Advance the queue head on a drained request
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (take) begin
      if (res.first_valid) begin
        q_nxt[cnt_after_pop[0]] = res.first;
      end
      // A second result only comes with an empty queue, so it lands behind the first
      if (res.second_valid) begin
        q_nxt[1] = res.second;
      end
      cnt_nxt = fill[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_BYTES   = 4096;
  localparam int unsigned QUIET_LIMIT = 5000; // cycles with no request moving
  localparam int unsigned TAIL_CYCLES = 20;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  cfd_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  cfd_pkg::out_t out_data;

  checksummed_frame_deframer_unit #(
    .MAX_FRAME_BYTES(MAX_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle rates in percent, changed between phases
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned items_sent         = 0;
  int unsigned mismatches         = 0;
  int unsigned quiet_cycles       = 0;

  // Results still owed by the block, oldest first
  cfd_pkg::out_t results_due[$];

  // Frame under construction, sent front to back
  logic [7:0] frame_buf[$];

  // Header state tracked alongside the block
  logic [12:0] rx_pos;
  logic [19:0] hdr_sum;
  logic [7:0]  even_byte;
  logic        type_wrong;
  logic [15:0] csum_rx;
  logic [15:0] len_rx;
  logic [7:0]  index_rx;
  logic [7:0]  count_rx;
  logic [15:0] fnum_rx;
  logic [63:0] id_rx;

  // Fold the carries back in and complement: ones'-complement checksum
  function automatic logic [15:0] fold_sum(input logic [31:0] s);
    logic [31:0] t;
    t = s;
    while (t[31:16] != 16'd0)
      t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
    return ~t[15:0];
  endfunction

  task automatic clear_frame_state();
    rx_pos     = '0;
    hdr_sum    = '0;
    even_byte  = '0;
    type_wrong = 1'b0;
    csum_rx    = '0;
    len_rx     = '0;
    index_rx   = '0;
    count_rx   = '0;
    fnum_rx    = '0;
    id_rx      = '0;
  endtask

  // Advance the header state by one accepted byte and queue what it yields:
  // a payload result from offset 24 on, then a status result on the last byte.
  task automatic deframe_byte(input logic [7:0] b, input logic last);
    int unsigned   pos;
    int unsigned   cnt;
    cfd_pkg::out_t r;
    pos = rx_pos;
    if (pos < cfd_pkg::SUM_BYTES) begin
      // Little-endian words: the even offset is the low half
      if (pos % 2 == 0)
        even_byte = b;
      else
        hdr_sum = hdr_sum + {4'd0, b, even_byte};
    end
    if (pos == cfd_pkg::TYPE_POS)
      type_wrong = (b != cfd_pkg::TYPE_VALUE);
    else if (pos >= cfd_pkg::ID_FIRST && pos <= cfd_pkg::ID_LAST)
      id_rx = {id_rx[55:0], b};
    else if (pos == cfd_pkg::LEN_HI_POS || pos == cfd_pkg::LEN_LO_POS)
      len_rx = {len_rx[7:0], b};
    else if (pos == cfd_pkg::CSUM_HI_POS || pos == cfd_pkg::CSUM_LO_POS)
      csum_rx = {csum_rx[7:0], b};
    else if (pos == cfd_pkg::INDEX_POS)
      index_rx = b;
    else if (pos == cfd_pkg::COUNT_POS)
      count_rx = b;
    else if (pos == cfd_pkg::FNUM_HI_POS || pos == cfd_pkg::FNUM_LO_POS)
      fnum_rx = {fnum_rx[7:0], b};

    if (pos >= cfd_pkg::HDR_BYTES) begin
      r              = '0;
      r.kind         = cfd_pkg::KIND_PAYLOAD;
      r.status       = cfd_pkg::STATUS_OK;
      r.payload_byte = b;
      r.end_of_run   = !last;
      results_due.push_back(r);
    end

    // Count saturates one past the maximum so overlong frames stay overlong
    if (rx_pos < MAX_BYTES + 1)
      rx_pos = rx_pos + 13'd1;
    cnt = rx_pos;

    if (last) begin
      r      = '0;
      r.kind = cfd_pkg::KIND_STATUS;
      // Checks in priority order; each needs its bytes to have arrived
      if (cnt >= cfd_pkg::TYPE_OK_MIN && type_wrong)
        r.status = cfd_pkg::STATUS_BAD_TYPE;
      else if (cnt >= cfd_pkg::CSUM_OK_MIN && csum_rx != fold_sum({12'd0, hdr_sum}))
        r.status = cfd_pkg::STATUS_BAD_CSUM;
      else if (cnt < cfd_pkg::HDR_BYTES || cnt > MAX_BYTES)
        r.status = cfd_pkg::STATUS_BAD_LEN;
      else if (len_rx - cfd_pkg::LEN_BIAS != 16'(cnt - cfd_pkg::HDR_BYTES))
        r.status = cfd_pkg::STATUS_BAD_LEN;
      else
        r.status = cfd_pkg::STATUS_OK;
      r.pkt_index      = index_rx;
      r.packet_count   = count_rx;
      r.frame_number   = fnum_rx;
      r.device_id      = id_rx;
      r.payload_length = len_rx - cfd_pkg::LEN_BIAS;
      r.end_of_run     = 1'b1;
      results_due.push_back(r);
      clear_frame_state();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Receiver: stall at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Compare every result that leaves the block with the oldest one owed
  always @(posedge clk) begin : check_results
    cfd_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = results_due.pop_front();
        check_field("kind", out_data.kind, want.kind);
        check_field("payload_byte", out_data.payload_byte, want.payload_byte);
        check_field("status", out_data.status, want.status);
        check_field("pkt_index", out_data.pkt_index, want.pkt_index);
        check_field("packet_count", out_data.packet_count, want.packet_count);
        check_field("frame_number", out_data.frame_number, want.frame_number);
        check_field("device_id", out_data.device_id, want.device_id);
        check_field("payload_length", out_data.payload_length, want.payload_length);
        check_field("end_of_run", out_data.end_of_run, want.end_of_run);
      end
    end
  end

  // Watchdog: give up once no request has moved on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("checksummed_frame_deframer_unit test failed");
      $finish;
    end
  end

  // Offer one byte, idling first at the phase rate, and hold it until taken.
  // Valid stays high on return so back-to-back requests need no gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    cfd_pkg::in_t req;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    req.rx_byte   = b;
    req.frame_end = last;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    deframe_byte(b, last);
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i])
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Build a header plus payload. A fill below zero means random bytes.
  // Skew the length field and flip checksum bits to break a frame on purpose.
  task automatic build_frame(input int unsigned n_payload, input int fill,
                             input logic [7:0] type_byte, input logic [15:0] len_skew,
                             input logic [15:0] csum_flip);
    logic [31:0] s;
    logic [15:0] w;
    frame_buf.delete();
    for (int i = 0; i < cfd_pkg::HDR_BYTES + n_payload; i++)
      frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    frame_buf[cfd_pkg::TYPE_POS] = type_byte;
    w = 16'(n_payload + cfd_pkg::LEN_BIAS) + len_skew;
    frame_buf[cfd_pkg::LEN_HI_POS] = w[15:8];
    frame_buf[cfd_pkg::LEN_LO_POS] = w[7:0];
    s = '0;
    for (int i = 0; i < cfd_pkg::SUM_BYTES; i += 2)
      s = s + {16'd0, frame_buf[i + 1], frame_buf[i]};
    w = fold_sum(s) ^ csum_flip;
    frame_buf[cfd_pkg::CSUM_HI_POS] = w[15:8];
    frame_buf[cfd_pkg::CSUM_LO_POS] = w[7:0];
  endtask

  // Drop valid and hold off until the block owes nothing
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0)
      @(posedge clk);
  endtask

  // A lone zero byte ends a frame at once; then a minimal frame, all ones but
  // for type, length and checksum, with one payload byte.
  task automatic test_directed();
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    send_frame();
    build_frame(1, 8'hff, cfd_pkg::TYPE_VALUE, 16'd0, 16'd0);
    send_frame();
  endtask

  task automatic test_random_frames(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned n_pay;
    int unsigned cut;
    logic [15:0] skew;
    logic [7:0]  bad_type;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick     = $urandom_range(99);
      n_pay    = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(12);
      bad_type = cfd_pkg::TYPE_VALUE ^ 8'($urandom_range(1, 255));
      if (pick < 55) begin
        build_frame(n_pay, -1, cfd_pkg::TYPE_VALUE, 16'd0, 16'd0);
      end else if (pick < 63) begin
        build_frame(n_pay, -1, bad_type, 16'd0, 16'd0);
      end else if (pick < 71) begin
        build_frame(n_pay, -1, cfd_pkg::TYPE_VALUE, 16'd0,
                    16'($urandom_range(1, 65535)));
      end else if (pick < 79) begin
        // Either a near miss or anything at all, wrap-around included
        if ($urandom_range(1) == 0)
          skew = 16'($urandom_range(1, 65535));
        else if ($urandom_range(1) == 0)
          skew = 16'($urandom_range(1, 3));
        else
          skew = -16'($urandom_range(1, 4));
        build_frame(n_pay, -1, cfd_pkg::TYPE_VALUE, skew, 16'd0);
      end else if (pick < 92) begin
        // Header cut short, type good or bad
        build_frame(0, -1, ($urandom_range(1) == 0) ? cfd_pkg::TYPE_VALUE : bad_type,
                    16'd0, 16'd0);
        cut = $urandom_range(1, cfd_pkg::HDR_BYTES - 1);
        while (frame_buf.size() > cut)
          void'(frame_buf.pop_back());
      end else begin
        frame_buf.delete();
        repeat ($urandom_range(1, 40))
          frame_buf.push_back(8'($urandom));
      end
      send_frame();
    end
  endtask

  initial begin
    clear_frame_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Sender rarely idles, receiver stalls often
    sender_idle_pct    = 6;
    receiver_stall_pct = 60;
    test_directed();
    test_random_frames(600);
    hold_until_drained();

    // Sender idles often, receiver rarely stalls
    sender_idle_pct    = 60;
    receiver_stall_pct = 6;
    test_random_frames(600);

    // Full rate on both sides
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    test_random_frames(600);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("checksummed_frame_deframer_unit test passed");
    else
      $display("checksummed_frame_deframer_unit test failed");
    $finish;
  end

endmodule
